>>> rtl/tetd_pkg.sv
// shared types and constants of the tick and event task dispatcher
`default_nettype none

package tetd_pkg;

    localparam int SLOTS       = 8;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 8;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int QIDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        CMD_REGISTER = 3'd0,
        CMD_FREE     = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_SET_EVT  = 3'd3,
        CMD_CLR_EVT  = 3'd4,
        CMD_DISPATCH = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_ALARM = 2'd1,
        KIND_TIMER = 2'd2,
        KIND_WATCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } t_state;

    // one queued result before uptime, flags and last are attached
    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
        logic       fired;
    } t_res;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        t_cmd op;
        logic scan_last;
        logic emit_last;
        logic out_free;
    } t_ctl_stat;

endpackage

`default_nettype wire

>>> rtl/tick_and_event_task_dispatcher_top.sv
// top level of the tick and event task dispatcher
//
//  channel  | direction | tdata / tuser / tlast
//  s_axis   | in        | commands: task_kind, arg_value, slot_number, event_number; tuser cmd
//  m_axis   | out       | results: status, slot_used, uptime, flags; tuser fired; tlast last
//  cfg      | in        | tick event number, written when i_cfg_we is high
//
// a command is accepted, then executed, then its results are emitted one after another
// a dispatch pass first scans the table, visiting every slot in turn
// the next transaction is taken once the previous results have entered the output register
// synchronous active-low reset frees all slots and clears flags and uptime
// a stalled output holds the scan or command results in the queue until taken
`default_nettype none

module tick_and_event_task_dispatcher_top
    import tetd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [3:0]            i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // task_kind[1:0], arg_value[17:2], slot_number[21:18], event_number[25:22], zeros
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  wire logic [2:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[1:0], slot_used[5:2], uptime[37:6], event_flags_out[53:38], zeros
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // fired[0]
    output logic [0:0]                 m_axis_tuser,
    output logic                       m_axis_tlast
);

    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    tetd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (ctl_stat),
        .o_cmd      (ctl_cmd)
    );

    tetd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (s_axis_tuser),
        .i_task_kind    (s_axis_tdata[1:0]),
        .i_arg_value    (s_axis_tdata[17:2]),
        .i_slot_number  (s_axis_tdata[21:18]),
        .i_event_number (s_axis_tdata[25:22]),
        .i_ctl          (ctl_cmd),
        .o_stat         (ctl_stat),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata),
        .o_out_fired    (m_axis_tuser[0]),
        .o_out_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/tetd_ctrl.sv
// controller state machine of the task dispatcher
`default_nettype none

module tetd_ctrl
    import tetd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_ctl_stat i_stat,
    output t_ctl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.op)
                    CMD_DISPATCH: n_state = S_SCAN;
                    CMD_REGISTER,
                    CMD_FREE,
                    CMD_TICK,
                    CMD_SET_EVT,
                    CMD_CLR_EVT:  n_state = S_EMIT;
                    default:      n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tetd_dp.sv
// datapath: slot table, event flags, uptime, result queue and output register
`default_nettype none

module tetd_dp
    import tetd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [3:0]            i_cfg_wdata,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [1:0]            i_task_kind,
    input  wire logic [15:0]           i_arg_value,
    input  wire logic [3:0]            i_slot_number,
    input  wire logic [3:0]            i_event_number,
    input  wire t_ctl_cmd              i_ctl,
    output t_ctl_stat                  o_stat,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic                       o_out_fired,
    output logic                       o_out_last
);

    // item registers
    t_cmd        r_op;
    logic [1:0]  r_task_kind;
    logic [15:0] r_arg;
    logic [3:0]  r_slot_in;
    logic [3:0]  r_evt;

    // slot table
    t_kind                 r_kind   [SLOTS];
    logic [COUNT_BITS-1:0] r_reload [SLOTS];
    logic [COUNT_BITS-1:0] r_count  [SLOTS];

    logic [15:0] r_pending;
    logic [31:0] r_uptime;
    logic [3:0]  r_tick_evt;
    logic        r_ticked;
    logic [SLOT_W-1:0] r_scan;

    // result queue
    t_res              r_queue [MAX_RESULTS];
    logic [RES_W-1:0]  r_nres;
    logic [QIDX_W-1:0] r_emit;

    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic        r_out_fired;
    logic        r_out_last;

    // first free slot
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_kind[i] == KIND_FREE) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    logic [COUNT_BITS-1:0] arg_cnt;
    t_kind                 new_kind;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     free_slot;

    assign arg_cnt   = COUNT_BITS'(r_arg);
    assign new_kind  = (r_task_kind >= 2'd2) ? KIND_WATCH : t_kind'(r_task_kind + 2'd1);
    assign slot_ok   = {1'b0, r_slot_in} < 5'(SLOTS);
    assign free_slot = SLOT_W'(r_slot_in);

    // one slot of the dispatch scan
    t_kind                 sc_kind;
    logic [COUNT_BITS-1:0] sc_reload;
    logic [COUNT_BITS-1:0] sc_dec;
    logic                  sc_fire;
    logic                  sc_evt_ok;
    t_kind                 n_sc_kind;
    logic [COUNT_BITS-1:0] n_sc_count;
    logic [15:0]           n_sc_pending;

    always_comb begin
        sc_kind      = r_kind[r_scan];
        sc_reload    = r_reload[r_scan];
        sc_dec       = r_count[r_scan] - COUNT_BITS'(1);
        sc_fire      = 1'b0;
        n_sc_kind    = sc_kind;
        n_sc_count   = r_count[r_scan];
        n_sc_pending = r_pending;
        sc_evt_ok    = (sc_reload >> 4) == '0;
        case (sc_kind)
            KIND_ALARM, KIND_TIMER: begin
                if (r_ticked) begin
                    n_sc_count = sc_dec;
                    if (sc_dec == '0) begin
                        sc_fire = 1'b1;
                        if (sc_kind == KIND_ALARM) begin
                            n_sc_kind = KIND_FREE;
                        end else begin
                            n_sc_count = sc_reload;
                        end
                    end
                end
            end
            KIND_WATCH: begin
                if (sc_evt_ok && r_pending[sc_reload[3:0]]) begin
                    sc_fire = 1'b1;
                    n_sc_pending[sc_reload[3:0]] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    logic sc_push;
    logic sc_quiet;
    assign sc_push  = sc_fire && (r_nres < RES_W'(MAX_RESULTS));
    assign sc_quiet = (r_scan == SLOT_W'(SLOTS - 1)) && !sc_fire && (r_nres == '0);

    // result of a single-result command
    t_res ex_res;
    always_comb begin
        ex_res = '0;
        case (r_op)
            CMD_REGISTER: begin
                ex_res.status = free_found ? ST_OK : ST_FULL;
                ex_res.slot   = free_found ? 4'(free_idx) : 4'd0;
            end
            CMD_FREE: begin
                ex_res.status = slot_ok ? ST_OK : ST_BAD_SLOT;
                ex_res.slot   = r_slot_in;
            end
            default: begin
                ex_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op        <= t_cmd'(i_cmd);
            r_task_kind <= i_task_kind;
            r_arg       <= i_arg_value;
            r_slot_in   <= i_slot_number;
            r_evt       <= i_event_number;
        end
        if (i_ctl.exec) begin
            case (r_op)
                CMD_REGISTER: begin
                    if (free_found) begin
                        r_reload[free_idx] <= arg_cnt;
                        r_count[free_idx]  <= arg_cnt;
                    end
                end
                CMD_DISPATCH: begin
                    r_ticked <= r_pending[r_tick_evt];
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.scan) begin
            r_count[r_scan] <= n_sc_count;
        end
        if (i_ctl.exec && r_op != CMD_DISPATCH) begin
            r_queue[0] <= ex_res;
        end
        if (i_ctl.scan && sc_push) begin
            r_queue[QIDX_W'(r_nres)] <= '{status: ST_OK, slot: 4'(r_scan), fired: 1'b1};
        end
        if (i_ctl.scan && sc_quiet) begin
            r_queue[0] <= '0;
        end
        if (i_ctl.emit) begin
            r_out_data  <= {2'b00, r_pending, r_uptime, r_queue[r_emit].slot,
                            r_queue[r_emit].status};
            r_out_fired <= r_queue[r_emit].fired;
            r_out_last  <= r_emit == QIDX_W'(r_nres - RES_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_kind[i] <= KIND_FREE;
            end
            r_pending   <= '0;
            r_uptime    <= '0;
            r_tick_evt  <= '0;
            r_scan      <= '0;
            r_nres      <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_evt <= i_cfg_wdata;
            end
            if (i_ctl.load) begin
                r_nres <= '0;
                r_emit <= '0;
                r_scan <= '0;
            end
            if (i_ctl.exec) begin
                case (r_op)
                    CMD_REGISTER: begin
                        if (free_found) begin
                            r_kind[free_idx] <= new_kind;
                        end
                        r_nres <= RES_W'(1);
                    end
                    CMD_FREE: begin
                        if (slot_ok) begin
                            r_kind[free_slot] <= KIND_FREE;
                        end
                        r_nres <= RES_W'(1);
                    end
                    CMD_TICK: begin
                        r_uptime              <= r_uptime + 32'd1;
                        r_pending[r_tick_evt] <= 1'b1;
                        r_nres                <= RES_W'(1);
                    end
                    CMD_SET_EVT: begin
                        r_pending[r_evt] <= 1'b1;
                        r_nres           <= RES_W'(1);
                    end
                    CMD_CLR_EVT: begin
                        r_pending[r_evt] <= 1'b0;
                        r_nres           <= RES_W'(1);
                    end
                    CMD_DISPATCH: begin
                        // tick flag is taken before the scan
                        r_pending[r_tick_evt] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.scan) begin
                r_kind[r_scan] <= n_sc_kind;
                r_pending      <= n_sc_pending;
                r_scan         <= r_scan + SLOT_W'(1);
                if (sc_push || sc_quiet) begin
                    r_nres <= r_nres + RES_W'(1);
                end
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
                r_emit      <= r_emit + QIDX_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.scan_last = r_scan == SLOT_W'(SLOTS - 1);
    assign o_stat.emit_last = r_emit == QIDX_W'(r_nres - RES_W'(1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_fired = r_out_fired;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> tb/sv/tb_tick_and_event_task_dispatcher_top.sv
// self-checking testbench for the tick and event task dispatcher top level
`default_nettype none

module tb_tick_and_event_task_dispatcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tetd_pkg::*;

    // task_kind encoding on the command stream differs from the slot table kinds
    localparam logic [1:0] REQ_ALARM  = 2'd0;
    localparam logic [1:0] REQ_TIMER  = 2'd1;
    localparam logic [1:0] REQ_WATCH  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // command codes outside the decoded set
    localparam logic [2:0] CMD_UNKNOWN_A = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN_B = 3'd7;

    localparam int DRAIN_CYCLES  = 3 * SLOTS + 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 40;
    localparam int DIRECTED_ROWS = 25;

    typedef struct {
        t_status     status;
        logic [3:0]  slot;
        logic        fired;
        logic        last;
        logic [31:0] uptime;
        logic [15:0] flags;
    } report_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [1:0]  kind;
        logic [15:0] arg;
        logic [3:0]  slot;
        logic [3:0]  evt;
        bit          typed;
        t_status     st;
        logic [3:0]  sl;
    } cmd_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [3:0]            i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    tick_and_event_task_dispatcher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predicted dispatcher state
    t_kind                 slot_kinds  [SLOTS];
    logic [COUNT_BITS-1:0] slot_reloads[SLOTS];
    logic [COUNT_BITS-1:0] slot_counts [SLOTS];
    logic [15:0]           event_flags;
    logic [31:0]           tick_count;
    logic [3:0]            tick_event;

    report_t expected_reports[$];

    int errors;
    int commands_sent;
    int reports_checked;
    int fired_seen;
    int full_seen;
    int bad_slot_seen;
    int stalled_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;

    cmd_row_t directed_rows[DIRECTED_ROWS] = '{
        '{CMD_FREE,     REQ_ALARM,  16'h0000, 4'd15, 4'd0,  1'b1, ST_BAD_SLOT, 4'd15},
        '{CMD_FREE,     REQ_ALARM,  16'h0000, 4'd8,  4'd0,  1'b1, ST_BAD_SLOT, 4'd8},
        '{CMD_REGISTER, REQ_ALARM,  16'd2,    4'd0,  4'd0,  1'b1, ST_OK,       4'd0},
        '{CMD_REGISTER, REQ_TIMER,  16'd1,    4'd0,  4'd0,  1'b1, ST_OK,       4'd1},
        '{CMD_REGISTER, REQ_WATCH,  16'd5,    4'd0,  4'd0,  1'b1, ST_OK,       4'd2},
        // unused kind registers a watcher, sharing event 5 with slot 2
        '{CMD_REGISTER, REQ_UNUSED, 16'd5,    4'd0,  4'd0,  1'b1, ST_OK,       4'd3},
        // watcher on the tick flag
        '{CMD_REGISTER, REQ_WATCH,  16'd0,    4'd0,  4'd0,  1'b1, ST_OK,       4'd4},
        // watcher on an event number past the flag word
        '{CMD_REGISTER, REQ_WATCH,  16'hFFFF, 4'd0,  4'd0,  1'b1, ST_OK,       4'd5},
        // zero count wraps on first decrement
        '{CMD_REGISTER, REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b1, ST_OK,       4'd6},
        '{CMD_REGISTER, REQ_TIMER,  16'hFFFF, 4'd0,  4'd0,  1'b1, ST_OK,       4'd7},
        '{CMD_REGISTER, REQ_TIMER,  16'd3,    4'd0,  4'd0,  1'b1, ST_FULL,     4'd0},
        '{CMD_DISPATCH, REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_SET_EVT,  REQ_ALARM,  16'h0000, 4'd0,  4'd5,  1'b0, ST_OK,       4'd0},
        '{CMD_SET_EVT,  REQ_ALARM,  16'h0000, 4'd0,  4'd15, 1'b0, ST_OK,       4'd0},
        '{CMD_TICK,     REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_DISPATCH, REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_TICK,     REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_DISPATCH, REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_CLR_EVT,  REQ_ALARM,  16'h0000, 4'd0,  4'd15, 1'b0, ST_OK,       4'd0},
        '{CMD_CLR_EVT,  REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0},
        '{CMD_UNKNOWN_A, REQ_UNUSED, 16'hAAAA, 4'd10, 4'd5, 1'b0, ST_OK,       4'd0},
        '{CMD_UNKNOWN_B, REQ_WATCH,  16'h5555, 4'd5,  4'd10, 1'b0, ST_OK,      4'd0},
        '{CMD_FREE,     REQ_ALARM,  16'h0000, 4'd7,  4'd0,  1'b1, ST_OK,       4'd7},
        '{CMD_FREE,     REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b1, ST_OK,       4'd0},
        '{CMD_DISPATCH, REQ_ALARM,  16'h0000, 4'd0,  4'd0,  1'b0, ST_OK,       4'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // work out the reports one command causes and update the predicted state
    task automatic apply_command(input logic [2:0] cmd, input logic [1:0] kind,
                                 input logic [15:0] arg, input logic [3:0] slot,
                                 input logic [3:0] evt);
        report_t               batch[$];
        report_t               r;
        logic [15:0]           tbit;
        logic [COUNT_BITS-1:0] watched;
        bit                    ticked;
        bit                    hit;
        bit                    fire;
        int                    i;

        r = '{ST_OK, 4'd0, 1'b0, 1'b0, 32'd0, 16'd0};
        case (cmd)
            CMD_REGISTER: begin
                hit = 1'b0;
                for (i = 0; i < SLOTS && !hit; i++) begin
                    if (slot_kinds[i] == KIND_FREE) begin
                        case (kind)
                            REQ_ALARM: slot_kinds[i] = KIND_ALARM;
                            REQ_TIMER: slot_kinds[i] = KIND_TIMER;
                            default:   slot_kinds[i] = KIND_WATCH;
                        endcase
                        slot_reloads[i] = arg[COUNT_BITS-1:0];
                        slot_counts[i]  = arg[COUNT_BITS-1:0];
                        r.slot = 4'(i);
                        hit = 1'b1;
                    end
                end
                if (!hit) r.status = ST_FULL;
                batch.push_back(r);
            end
            CMD_FREE: begin
                r.slot = slot;
                if (slot < SLOTS) begin
                    slot_kinds[slot]   = KIND_FREE;
                    slot_reloads[slot] = '0;
                    slot_counts[slot]  = '0;
                end else begin
                    r.status = ST_BAD_SLOT;
                end
                batch.push_back(r);
            end
            CMD_TICK: begin
                tick_count++;
                event_flags[tick_event] = 1'b1;
                batch.push_back(r);
            end
            CMD_SET_EVT: begin
                event_flags[evt] = 1'b1;
                batch.push_back(r);
            end
            CMD_CLR_EVT: begin
                event_flags[evt] = 1'b0;
                batch.push_back(r);
            end
            CMD_DISPATCH: begin
                tbit   = 16'd1 << tick_event;
                ticked = (event_flags & tbit) != 16'd0;
                event_flags &= ~tbit;
                for (i = 0; i < SLOTS; i++) begin
                    fire = 1'b0;
                    if (slot_kinds[i] == KIND_ALARM || slot_kinds[i] == KIND_TIMER) begin
                        if (ticked) begin
                            slot_counts[i] = slot_counts[i] - 1'b1;
                            if (slot_counts[i] == '0) begin
                                fire = 1'b1;
                                if (slot_kinds[i] == KIND_ALARM) begin
                                    slot_kinds[i]   = KIND_FREE;
                                    slot_reloads[i] = '0;
                                end else begin
                                    slot_counts[i] = slot_reloads[i];
                                end
                            end
                        end
                    end else if (slot_kinds[i] == KIND_WATCH) begin
                        watched = slot_reloads[i];
                        if (watched < 16 && event_flags[watched[3:0]]) begin
                            fire = 1'b1;
                            event_flags[watched[3:0]] = 1'b0;
                        end
                    end
                    if (fire && batch.size() < MAX_RESULTS) begin
                        r.slot  = 4'(i);
                        r.fired = 1'b1;
                        batch.push_back(r);
                    end
                end
                if (batch.size() == 0) batch.push_back(r);
            end
            default: ;
        endcase

        foreach (batch[k]) begin
            batch[k].last   = (k == batch.size() - 1);
            batch[k].uptime = tick_count;
            batch[k].flags  = event_flags;
            expected_reports.push_back(batch[k]);
        end
    endtask

    // offer one command and wait until it is taken; tvalid stays high afterwards
    task automatic send_command(input cmd_row_t row);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.cmd;
        s_axis_tdata  <= {6'd0, row.evt, row.slot, row.arg, row.kind};
        do @(posedge i_clk); while (!s_axis_tready);
        commands_sent++;
        apply_command(row.cmd, row.kind, row.arg, row.slot, row.evt);
        if (row.typed) begin
            expected_reports[expected_reports.size() - 1].status = row.st;
            expected_reports[expected_reports.size() - 1].slot   = row.sl;
        end
    endtask

    task automatic send_plain(input logic [2:0] cmd, input logic [1:0] kind,
                              input logic [15:0] arg, input logic [3:0] slot,
                              input logic [3:0] evt);
        cmd_row_t row;
        row = '{cmd, kind, arg, slot, evt, 1'b0, ST_OK, 4'd0};
        send_command(row);
    endtask

    // weighted mix: mostly meaningful commands with noise in the unused fields
    task automatic send_random_command();
        logic [2:0]  cmd;
        logic [1:0]  kind;
        logic [15:0] arg;
        logic [3:0]  slot;
        logic [3:0]  evt;
        int          pick;

        kind = 2'($urandom);
        arg  = 16'($urandom);
        slot = 4'($urandom);
        evt  = 4'($urandom);
        pick = $urandom_range(99);
        if (pick < 22) begin
            cmd = CMD_REGISTER;
            if (kind == REQ_ALARM || kind == REQ_TIMER) begin
                if ($urandom_range(9) != 0) arg = 16'($urandom_range(1, 4));
            end else if ($urandom_range(7) != 0) begin
                arg = 16'($urandom_range(15));
            end
        end else if (pick < 32) begin
            cmd = CMD_FREE;
            if ($urandom_range(4) != 0) slot = 4'($urandom_range(SLOTS - 1));
        end else if (pick < 52) begin
            cmd = CMD_TICK;
        end else if (pick < 67) begin
            cmd = CMD_SET_EVT;
        end else if (pick < 72) begin
            cmd = CMD_CLR_EVT;
        end else if (pick < 95) begin
            cmd = CMD_DISPATCH;
        end else begin
            cmd = $urandom_range(1) ? CMD_UNKNOWN_A : CMD_UNKNOWN_B;
        end
        send_plain(cmd, kind, arg, slot, evt);
    endtask

    // every slot a one-tick timer, then a pass that fires all of them
    task automatic send_full_fire_burst();
        int i;
        for (i = 0; i < SLOTS; i++) send_plain(CMD_FREE, REQ_ALARM, 16'd0, 4'(i), 4'd0);
        for (i = 0; i < SLOTS; i++) send_plain(CMD_REGISTER, REQ_TIMER, 16'd1, 4'd0, 4'd0);
        send_plain(CMD_TICK, REQ_ALARM, 16'd0, 4'd0, 4'd0);
        send_plain(CMD_DISPATCH, REQ_ALARM, 16'd0, 4'd0, 4'd0);
    endtask

    // drain, let a trailing unknown command finish, then write the tick event number
    task automatic write_tick_event(input logic [3:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tick_event = value;
    endtask

    // receiver: random back-pressure plus a long hold-off when the stimulus requests one
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser[0]) fired_seen++;
            if (m_axis_tdata[1:0] == ST_FULL) full_seen++;
            if (m_axis_tdata[1:0] == ST_BAD_SLOT) bad_slot_seen++;
            if (expected_reports.size() == 0) begin
                $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (m_axis_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[5:2] !== want.slot) begin
                    $error("slot_used: expected %0d, got %0d", want.slot, m_axis_tdata[5:2]);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[37:6] !== want.uptime) begin
                    $error("uptime: expected %0d, got %0d", want.uptime, m_axis_tdata[37:6]);
                    errors++;
                end
                if (m_axis_tdata[53:38] !== want.flags) begin
                    $error("event_flags_out: expected %h, got %h", want.flags,
                           m_axis_tdata[53:38]);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with work outstanding and no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (expected_reports.size() == 0 && !s_axis_tvalid)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("tick_and_event_task_dispatcher_top regression: fail");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        int ph;
        int n;

        errors          = 0;
        commands_sent   = 0;
        reports_checked = 0;
        fired_seen      = 0;
        full_seen       = 0;
        bad_slot_seen   = 0;
        stalled_cycles  = 0;
        hold_req        = 1'b0;
        hold_left       = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        for (n = 0; n < SLOTS; n++) begin
            slot_kinds[n]   = KIND_FREE;
            slot_reloads[n] = '0;
            slot_counts[n]  = '0;
        end
        event_flags = '0;
        tick_count  = '0;
        tick_event  = '0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_tick_event(4'd0);
        for (n = 0; n < DIRECTED_ROWS; n++) send_command(directed_rows[n]);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 58;
                    write_tick_event(4'd15);
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 13;
                    write_tick_event(4'($urandom_range(1, 14)));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_tick_event(4'd0);
                    // receiver stops while commands keep coming
                    hold_req = 1'b1;
                end
            endcase
            send_full_fire_burst();
            for (n = 0; n < RANDOM_ITEMS; n++) send_random_command();
        end

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands over three back-pressure mixes and tick events 0/15/mid",
                 commands_sent);
        $display("checked %0d results: %0d fired slots, %0d table full, %0d bad slot",
                 reports_checked, fired_seen, full_seen, bad_slot_seen);
        if (errors == 0) begin
            $display("tick_and_event_task_dispatcher_top regression: pass");
        end else begin
            $display("tick_and_event_task_dispatcher_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
